>>> design/page_framebuffer_pixel_engine_top_assert.svh
// assertion macros for the page framebuffer pixel engine
// used by page_framebuffer_pixel_engine_top, no other dependencies
`ifndef PAGE_FRAMEBUFFER_PIXEL_ENGINE_TOP_ASSERT_SVH
`define PAGE_FRAMEBUFFER_PIXEL_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define PFPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pfpe_pkg.sv
// shared types, codes and constants of the page framebuffer pixel engine
// no dependencies
`default_nettype none

package pfpe_pkg;

  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned ROWS_DEF    = 64;
  localparam int unsigned CMD_STEPS   = 3;

  localparam logic [7:0] PAGE_CMD   = 8'hb0;
  localparam logic [7:0] COL_HI_CMD = 8'h10;
  localparam logic [7:0] BYTE_ONES  = 8'hff;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

  // configuration port
  localparam int unsigned APB_AW            = 3;
  localparam int unsigned REG_COLUMN_OFFSET = 0;
  localparam logic [3:0]  OFFSET_RESET      = 4'd2;

  localparam logic [1:0] OP_POINT   = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  localparam logic [1:0] PEN_OFF    = 2'd0;
  localparam logic [1:0] PEN_ON     = 2'd1;
  localparam logic [1:0] PEN_INVERT = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic [1:0]        pen;
  } pfpe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
  } pfpe_out_t;

  // controller to datapath
  typedef struct packed {
    logic pt_rd;
    logic pt_wr;
    logic fill_start;
    logic fill_rd;
    logic fill_wr;
    logic clear_wr;
    logic ref_rd;
    logic ref_load;
  } pfpe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_panel;
    logic sweep_last;
    logic out_free;
  } pfpe_status_t;

endpackage

`default_nettype wire

>>> design/pfpe_ctrl.sv
// controller state machine of the page framebuffer pixel engine
// depends on pfpe_pkg, drives pfpe_datapath through pfpe_cmd_t
`default_nettype none

module pfpe_ctrl
  import pfpe_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic [1:0]   operation_i,
  output logic              in_ready_o,
  input  wire pfpe_status_t status_i,
  output pfpe_cmd_t         cmd_o
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_PT_WR   = 3'd2;
  localparam logic [2:0] ST_FILL_RD = 3'd3;
  localparam logic [2:0] ST_FILL_WR = 3'd4;
  localparam logic [2:0] ST_REF_OUT = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        // clearing pass after reset
        cmd_o.clear_wr = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_POINT: begin
              if (status_i.in_panel) begin
                cmd_o.pt_rd = 1'b1;
                state_d     = ST_PT_WR;
              end
            end
            OP_FILL: begin
              cmd_o.fill_start = 1'b1;
              state_d          = ST_FILL_RD;
            end
            OP_REFRESH: begin
              cmd_o.ref_rd = 1'b1;
              state_d      = ST_REF_OUT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_PT_WR: begin
        cmd_o.pt_wr = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_FILL_RD: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = status_i.sweep_last ? ST_IDLE : ST_FILL_RD;
      end
      ST_REF_OUT: begin
        // wait for the output slot
        if (status_i.out_free) begin
          cmd_o.ref_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/pfpe_datapath.sv
// datapath of the page framebuffer pixel engine: frame store, sweep and
// refresh counters, output register; depends on pfpe_pkg
`default_nettype none

module pfpe_datapath
  import pfpe_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pfpe_in_t   in_data_i,
  input  wire logic [3:0] column_offset_i,
  input  wire pfpe_cmd_t  cmd_i,
  output pfpe_status_t    status_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output pfpe_out_t       out_data_o
);

  localparam int unsigned PAGES = (ROWS + 7) / 8;
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned AW    = PW + CW;
  localparam int unsigned DEPTH = 1 << AW;

  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);
  localparam logic [7:0]    POS_LAST  = 8'(CMD_STEPS + COLUMNS - 1);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // point decode from the incoming request
  logic [7:0]    x_u, y_u, y_sh;
  logic [AW-1:0] pt_addr;
  logic [AW-1:0] pt_addr_q;
  logic [7:0]    pt_mask_q;
  logic [1:0]    pen_q;

  // sweep and refresh counters
  logic [CW-1:0] sw_col_q;
  logic [PW-1:0] sw_page_q;
  logic [PW-1:0] ref_page_q;
  logic [7:0]    ref_pos_q;
  logic [7:0]    ref_dc;
  logic          sweep_last;

  logic          out_valid_q;
  pfpe_out_t     out_q, out_d;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data, pt_wdata, fill_wdata;

  assign x_u     = in_data_i.x;
  assign y_u     = in_data_i.y;
  assign y_sh    = y_u >> 3;
  assign pt_addr = {y_sh[PW-1:0], x_u[CW-1:0]};

  assign status_o.in_panel = !x_u[7] && !y_u[7] && (x_u < 8'(COLUMNS)) &&
                             (y_u < 8'(ROWS));

  assign sweep_last          = (sw_col_q == COL_LAST) && (sw_page_q == PAGE_LAST);
  assign status_o.sweep_last = sweep_last;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign ref_dc = ref_pos_q - 8'(CMD_STEPS);

  // point modify
  always_comb begin
    case (pen_q)
      PEN_ON:     pt_wdata = rdata_q | pt_mask_q;
      PEN_INVERT: pt_wdata = rdata_q ^ pt_mask_q;
      default:    pt_wdata = rdata_q & ~pt_mask_q;
    endcase
  end

  always_comb begin
    case (pen_q)
      PEN_ON:  fill_wdata = BYTE_ONES;
      PEN_OFF: fill_wdata = BYTE_ZERO;
      default: fill_wdata = ~rdata_q;
    endcase
  end

  always_comb begin
    rd_en   = cmd_i.pt_rd || cmd_i.fill_rd || cmd_i.ref_rd;
    rd_addr = {sw_page_q, sw_col_q};
    if (cmd_i.pt_rd) begin
      rd_addr = pt_addr;
    end else if (cmd_i.ref_rd) begin
      rd_addr = {ref_page_q, ref_dc[CW-1:0]};
    end
    wr_en   = cmd_i.pt_wr || cmd_i.fill_wr || cmd_i.clear_wr;
    wr_addr = {sw_page_q, sw_col_q};
    wr_data = BYTE_ZERO;
    if (cmd_i.pt_wr) begin
      wr_addr = pt_addr_q;
      wr_data = pt_wdata;
    end else if (cmd_i.fill_wr) begin
      wr_data = fill_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_rd) begin
      pt_addr_q <= pt_addr;
      pt_mask_q <= 8'd1 << y_u[2:0];
    end
    if (cmd_i.pt_rd || cmd_i.fill_start) begin
      pen_q <= in_data_i.pen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_col_q  <= '0;
      sw_page_q <= '0;
    end else if (cmd_i.fill_start) begin
      sw_col_q  <= '0;
      sw_page_q <= '0;
    end else if (cmd_i.fill_wr || cmd_i.clear_wr) begin
      if (sw_col_q == COL_LAST) begin
        sw_col_q  <= '0;
        sw_page_q <= (sw_page_q == PAGE_LAST) ? '0 : sw_page_q + PW'(1);
      end else begin
        sw_col_q <= sw_col_q + CW'(1);
      end
    end
  end

  // refresh stream byte
  always_comb begin
    out_d.is_data   = 1'b0;
    out_d.frame_end = 1'b0;
    case (ref_pos_q)
      8'd0:    out_d.out_byte = PAGE_CMD + 8'(ref_page_q);
      8'd1:    out_d.out_byte = COL_HI_CMD;
      8'd2:    out_d.out_byte = {4'd0, column_offset_i};
      default: begin
        out_d.out_byte  = rdata_q;
        out_d.is_data   = 1'b1;
        out_d.frame_end = (ref_pos_q == POS_LAST) && (ref_page_q == PAGE_LAST);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_page_q <= '0;
      ref_pos_q  <= '0;
    end else if (cmd_i.ref_load) begin
      if (ref_pos_q >= POS_LAST) begin
        ref_pos_q  <= '0;
        ref_page_q <= (ref_page_q == PAGE_LAST) ? '0 : ref_page_q + PW'(1);
      end else begin
        ref_pos_q <= ref_pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ref_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ref_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> design/page_framebuffer_pixel_engine_top.sv
// top level of the page framebuffer pixel engine: config register and glue
// depends on pfpe_pkg, pfpe_ctrl, pfpe_datapath and the assertion header
//
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i (pfpe_in_t)
// out       output     out_valid_o / out_ready_i out_data_o (pfpe_out_t)
// config    input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// draw point: store read, then write back; off-panel point: taken with no store access
// refresh tick: store read, plus any wait for the output register to drain
// fill: read and write back per store byte, COLUMNS*PAGES bytes, one port
// after reset a clearing pass over COLUMNS*PAGES bytes runs before requests
// are taken; config writes are taken at any time
`default_nettype none

module page_framebuffer_pixel_engine_top
  import pfpe_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pfpe_in_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pfpe_out_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

`include "page_framebuffer_pixel_engine_top_assert.svh"

  logic [3:0]   column_offset_q;
  logic         reg_hit;
  pfpe_cmd_t    cmd;
  pfpe_status_t status;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == 1'(REG_COLUMN_OFFSET));
  assign prdata  = reg_hit ? {28'd0, column_offset_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_offset_q <= OFFSET_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      column_offset_q <= pwdata[3:0];
    end
  end

  pfpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (in_data_i.operation),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfpe_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_data_i       (in_data_i),
    .column_offset_i (column_offset_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_data_o      (out_data_o)
  );

  // a fill always holds off the next request
  `PFPE_ASSERT_NEXT(a_fill_stalls, clk_i, rst_ni,
    in_valid_i && in_ready_o && (in_data_i.operation == OP_FILL), !in_ready_o,
    "fill request did not stall the input")

  // the clearing pass never overlaps request intake
  `PFPE_ASSERT_IMPL(a_clear_no_accept, clk_i, rst_ni, cmd.clear_wr, !in_ready_o,
    "input ready during clearing pass")

  // a result appears only from a refresh load
  `PFPE_ASSERT_IMPL(a_out_from_load, clk_i, rst_ni, $rose(out_valid_o),
    $past(cmd.ref_load), "output valid without refresh load")

endmodule

`default_nettype wire

>>> tb/sv/pfpe_frame_checker.sv
// checker for the page framebuffer pixel engine: mirrors the frame store, the
// refresh stream and the column offset register, and checks every output byte
// depends on pfpe_pkg
module pfpe_frame_checker
  import pfpe_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pfpe_in_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pfpe_out_t         out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic [31:0]       prdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int unsigned PAGES      = (ROWS + 7) / 8;
  localparam int unsigned STORE_SIZE = COLUMNS * PAGES;
  localparam int unsigned LAST_STEP  = CMD_STEPS + COLUMNS - 1;
  localparam logic [APB_AW-1:0] OFFSET_ADDR = APB_AW'(REG_COLUMN_OFFSET * 4);

  logic [7:0] shadow_store [STORE_SIZE];
  logic [2:0] stream_page;
  logic [7:0] stream_step;
  logic [3:0] col_offset;
  pfpe_out_t  expected_bytes [$];
  int         mismatch_total = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  task automatic plot_pixel(input pfpe_in_t req);
    int         col;
    int         row;
    int         idx;
    logic [7:0] bit_mask;
    col = $signed(req.x);
    row = $signed(req.y);
    if (col < 0 || row < 0 || col >= int'(COLUMNS) || row >= int'(ROWS)) begin
      return;
    end
    idx      = (row / 8) * COLUMNS + col;
    bit_mask = 8'h01 << (row % 8);
    case (req.pen)
      PEN_ON:     shadow_store[idx] = shadow_store[idx] | bit_mask;
      PEN_INVERT: shadow_store[idx] = shadow_store[idx] ^ bit_mask;
      // clear, and the spare pen code behaves as clear
      default:    shadow_store[idx] = shadow_store[idx] & ~bit_mask;
    endcase
  endtask

  task automatic fill_screen(input logic [1:0] pen);
    foreach (shadow_store[i]) begin
      case (pen)
        PEN_ON:  shadow_store[i] = BYTE_ONES;
        PEN_OFF: shadow_store[i] = BYTE_ZERO;
        default: shadow_store[i] = BYTE_ONES - shadow_store[i];
      endcase
    end
  endtask

  task automatic stream_next_byte();
    pfpe_out_t   want;
    int unsigned col;
    want = '0;
    if (stream_step == 0) begin
      want.out_byte = PAGE_CMD + 8'(stream_page);
    end else if (stream_step == 1) begin
      want.out_byte = COL_HI_CMD | ({4'h0, col_offset} >> 4);
    end else if (stream_step == 2) begin
      want.out_byte = {4'h0, col_offset};
    end else begin
      col            = stream_step - CMD_STEPS;
      want.out_byte  = shadow_store[stream_page * COLUMNS + col];
      want.is_data   = 1'b1;
      want.frame_end = (col == COLUMNS - 1) && (stream_page == PAGES - 1);
    end
    expected_bytes.push_back(want);
    if (stream_step >= LAST_STEP) begin
      stream_step = '0;
      stream_page = (stream_page + 1 >= PAGES) ? 3'd0 : stream_page + 3'd1;
    end else begin
      stream_step = stream_step + 8'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pfpe_out_t got;
    pfpe_out_t want;
    if (!rst_ni) begin
      foreach (shadow_store[i]) begin
        shadow_store[i] = BYTE_ZERO;
      end
      stream_page = '0;
      stream_step = '0;
      col_offset  = OFFSET_RESET;
      expected_bytes.delete();
      pending_o    <= 0;
      fail_count_o <= mismatch_total;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == OFFSET_ADDR) begin
        if (pwrite_i) begin
          col_offset = pwdata_i[3:0];
        end else if (prdata_i !== {28'h0, col_offset}) begin
          report_mismatch($sformatf("column_offset read 0x%0h, expected 0x%0h",
                                    prdata_i, col_offset));
        end
      end

      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("output byte 0x%02h with none expected", got.out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                      got.out_byte, want.out_byte));
          end
          if (got.is_data !== want.is_data) begin
            report_mismatch($sformatf("is_data %b, expected %b (byte 0x%02h)",
                                      got.is_data, want.is_data, want.out_byte));
          end
          if (got.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, expected %b (byte 0x%02h)",
                                      got.frame_end, want.frame_end, want.out_byte));
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (in_data_i.operation)
          OP_POINT:   plot_pixel(in_data_i);
          OP_FILL:    fill_screen(in_data_i.pen);
          OP_REFRESH: stream_next_byte();
          default:    ;
        endcase
      end

      pending_o    <= expected_bytes.size();
      fail_count_o <= mismatch_total;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench top for the page framebuffer pixel engine: clock, reset, request
// and register stimulus, output back-pressure and the final verdict
// depends on pfpe_pkg, page_framebuffer_pixel_engine_top and pfpe_frame_checker
module tb_top;
  import pfpe_pkg::*;

  localparam int unsigned HALF_PERIOD    = 10;
  localparam int unsigned PAGES          = (ROWS_DEF + 7) / 8;
  localparam int unsigned STREAM_LEN     = CMD_STEPS + COLUMNS_DEF;
  localparam int unsigned SETTLE_CYCLES  = 2 * COLUMNS_DEF * PAGES + 32;
  localparam int unsigned NUM_PHASES     = 4;
  localparam int unsigned PHASE_ITEMS    = 205;
  localparam int unsigned CLOSING_ITEMS  = 100;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned TIMEOUT_CYCLES = 1000000;

  localparam logic [APB_AW-1:0] OFFSET_ADDR   = APB_AW'(REG_COLUMN_OFFSET * 4);
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'((REG_COLUMN_OFFSET + 1) * 4);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] PEN_SPARE = 2'd3;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid;
  logic              in_ready;
  pfpe_in_t          in_data;
  logic              out_valid;
  logic              out_ready;
  pfpe_out_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  bit idle_en  = 1'b0;
  bit hold_req = 1'b0;
  int ticks_sent = 0;

  always #HALF_PERIOD clk = ~clk;

  page_framebuffer_pixel_engine_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  pfpe_frame_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic pfpe_in_t make_req(input logic [1:0] op, input int x, input int y,
                                        input logic [1:0] pen);
    pfpe_in_t r;
    r.operation = op;
    r.x         = 8'(x);
    r.y         = 8'(y);
    r.pen       = pen;
    return r;
  endfunction

  function automatic pfpe_in_t random_request();
    pfpe_in_t    r;
    int unsigned pick;
    int unsigned frame_pos;
    int unsigned step;
    r.x   = 8'($urandom());
    r.y   = 8'($urandom());
    r.pen = 2'($urandom());
    pick  = $urandom_range(0, 99);
    if (pick < 75) begin
      r.operation = OP_REFRESH;
    end else if (pick < 96) begin
      r.operation = OP_POINT;
      frame_pos   = ticks_sent % (STREAM_LEN * PAGES);
      step        = frame_pos % STREAM_LEN;
      case ($urandom_range(0, 7))
        0: ;  // raw coordinates, mostly off the panel
        1, 2: begin
          // hit the byte that the stream is about to read
          if (step >= CMD_STEPS) begin
            r.x = 8'(step - CMD_STEPS);
            r.y = 8'((frame_pos / STREAM_LEN) * 8 + $urandom_range(0, 7));
          end
        end
        3, 4: begin
          r.x = 8'($urandom_range(0, 15));
          r.y = 8'($urandom_range(0, 15));
        end
        default: begin
          r.x = 8'($urandom_range(0, COLUMNS_DEF - 1));
          r.y = 8'($urandom_range(0, ROWS_DEF - 1));
        end
      endcase
    end else if (pick < 98) begin
      r.operation = OP_UNUSED;
    end else begin
      r.operation = OP_FILL;
    end
    return r;
  endfunction

  task automatic send_request(input pfpe_in_t req);
    if (idle_en && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (req.operation == OP_REFRESH) begin
      ticks_sent++;
    end
  endtask

  task automatic apb_access(input logic write, input logic [APB_AW-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, let every expected byte arrive, then cover a full fill pass
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long back-pressure so the block fills up and stalls its input
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 99) < 8) begin
        stall_left = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int         phase;
    logic [3:0] offset;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value, then a write past the register list that must not land
    apb_access(1'b0, OFFSET_ADDR, '0);
    apb_access(1'b1, UNMAPPED_ADDR, 32'hffff_ffff);
    apb_access(1'b0, OFFSET_ADDR, '0);

    send_request(make_req(OP_POINT, 0, 0, PEN_ON));
    send_request(make_req(OP_POINT, 127, 63, PEN_ON));
    send_request(make_req(OP_POINT, 2, 9, PEN_INVERT));
    send_request(make_req(OP_POINT, 2, 9, PEN_SPARE));
    send_request(make_req(OP_POINT, 2, 15, PEN_INVERT));
    send_request(make_req(OP_POINT, -1, 5, PEN_ON));
    send_request(make_req(OP_POINT, 5, -128, PEN_ON));
    send_request(make_req(OP_POINT, 3, 64, PEN_ON));
    send_request(make_req(OP_POINT, -128, 127, PEN_INVERT));
    send_request(make_req(OP_UNUSED, -1, -1, PEN_SPARE));
    repeat (4) send_request(make_req(OP_REFRESH, 0, 0, PEN_OFF));
    // write the column the stream reads right after
    send_request(make_req(OP_POINT, 1, 7, PEN_ON));
    repeat (2) send_request(make_req(OP_REFRESH, 0, 0, PEN_OFF));
    send_request(make_req(OP_FILL, 0, 0, PEN_INVERT));
    send_request(make_req(OP_REFRESH, 0, 0, PEN_OFF));
    send_request(make_req(OP_FILL, 0, 0, PEN_SPARE));
    send_request(make_req(OP_REFRESH, 0, 0, PEN_OFF));
    send_request(make_req(OP_FILL, 0, 0, PEN_ON));
    send_request(make_req(OP_REFRESH, 0, 0, PEN_OFF));
    send_request(make_req(OP_FILL, 0, 0, PEN_OFF));
    send_request(make_req(OP_REFRESH, 0, 0, PEN_OFF));

    for (phase = 0; phase < int'(NUM_PHASES); phase++) begin
      wait_idle();
      case (phase)
        0:       offset = 4'hf;
        1:       offset = 4'h0;
        2:       offset = OFFSET_RESET;
        default: offset = 4'($urandom());
      endcase
      apb_access(1'b1, OFFSET_ADDR, {28'($urandom()), offset});
      apb_access(1'b0, OFFSET_ADDR, '0);
      idle_en = (phase % 3 != 1);
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    // closing stretch with no idling on either side
    wait_idle();
    apb_access(1'b1, OFFSET_ADDR, {28'($urandom()), 4'($urandom())});
    idle_en = 1'b0;
    repeat (CLOSING_ITEMS) send_request(random_request());
    wait_idle();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
